// File: hdl/spectrum_trace_pixel_renderer_macros.svh
// Assertion macros for the spectrum trace renderer.
// Both expect signals named clock and reset in the scope where they are used.
`ifndef SPECTRUM_TRACE_PIXEL_RENDERER_MACROS_SVH
`define SPECTRUM_TRACE_PIXEL_RENDERER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STPR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stpr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define STPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stpr: next-cycle check failed");

`endif

// File: hdl/stpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stpr_pkg;

   localparam int COLUMNS  = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int MIN_ROWS = 2;

   localparam int COL_FIELD_W    = 10;
   localparam int ROW_FIELD_W    = 10;
   localparam int LEVEL_W        = 16;
   localparam int HEIGHT_FIELD_W = 11;
   localparam int COLOR_W        = 24;
   localparam int CHAN_W         = 8;
   localparam int NUM_CHAN       = 3;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_AW      = 3;

   localparam int COL_AW = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int H_W    = $clog2(MAX_ROWS + 1);
   // Wide enough to compare any field or row against any bound.
   localparam int CMP_W  = 13;

   // Gradient numerator is below 256 * height; the reciprocal is scaled to the same width.
   localparam int N_W          = CHAN_W + ROW_W;
   localparam int RECIP_W      = N_W;
   localparam int RECIP_STEPS  = N_W + 1;
   localparam int RECIP_CNT_W  = $clog2(RECIP_STEPS);

   localparam int H_RESET     = 500;
   localparam int RECIP_RESET = (1 << N_W) / H_RESET;

   localparam logic [CHAN_W-1:0] WHITE_LEVEL = 8'd255;
   localparam logic [CHAN_W-1:0] GREY_LEVEL  = 8'd180;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_PIXEL = 1'b1
   } command_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_HEIGHT      = 3'd0,
      REG_BACK_TOP    = 3'd1,
      REG_BACK_BOTTOM = 3'd2,
      REG_FORE_TOP    = 3'd3,
      REG_FORE_BOTTOM = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_WHITE,
      KIND_GREY,
      KIND_BACK,
      KIND_FORE
   } kind_type;

   typedef struct packed {
      logic [ROW_FIELD_W-1:0] y;
      logic                   first_col;
      logic                   in_range;
   } pix_meta_type;

   typedef struct packed {
      logic               busy;
      logic [RECIP_W-1:0] value;
   } recip_type;

endpackage

`default_nettype wire

// File: hdl/spectrum_trace_pixel_renderer.sv
`timescale 1ns / 1ps
`default_nettype none

// Spectrum trace pixel renderer.
// req channel: one beat per command. tuser selects a level load or a pixel request; tdata
// carries column, row and level. A load stores the column's trace row and gives no beat
// on rsp; a pixel request gives exactly one rsp beat with the pixel's red, green and blue.
// Results leave in request order through the input register, the classify, numerator and
// quotient stages and the output register. Throughput is one beat per cycle while rsp is
// ready and no reciprocal runs, loads and pixel requests freely mixed: the column rows sit
// in two copies of a 1-port-write, 1-port-read RAM, one read at the column and one at the
// column before it, so both rows of a request are read together. Writing plot_height starts
// a bit-per-cycle reciprocal of the height, which holds req off until it is done; the colour
// registers take effect at once. Reset loads the register defaults and empties the
// pipeline; the column rows are not cleared, so every column must be loaded before it
// is drawn. When rsp stalls, results queue up in the five pipeline stages; req_tready
// falls through back-pressure only once every stage holds a result.
module spectrum_trace_pixel_renderer import stpr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // column [9:0], row [19:10], level [35:20]
   input  logic                   req_tuser,   // command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic                   csr_wen,
   input  logic [CSR_AW-1:0]      csr_addr,
   input  logic [COLOR_W-1:0]     csr_wdata
);

   logic [H_W-1:0]     height_ff, height_in;
   logic [COLOR_W-1:0] back_top_ff, back_top_in, back_bottom_ff, back_bottom_in;
   logic [COLOR_W-1:0] fore_top_ff, fore_top_in, fore_bottom_ff, fore_bottom_in;
   logic [CMP_W-1:0]   raw_height;
   logic               recip_start;
   recip_type          recip;

   logic [COL_FIELD_W-1:0] req_column;
   logic [ROW_FIELD_W-1:0] req_row;
   logic [LEVEL_W-1:0]     req_level;
   command_type            req_cmd;
   logic                   accept;
   logic                   en1, take;
   logic                   v1_ff, v1_in;
   pix_meta_type           meta1_ff, meta1_in;
   logic [COL_AW-1:0]      col_addr;
   logic                   col_ok;
   logic [LEVEL_W+H_W-1:0] load_prod;
   logic [ROW_W-1:0]       load_row;
   logic                   wr_en;
   logic [ROW_W-1:0]       cur_row, prev_row;

   // Configuration; the height saturates as it is written.
   always_comb begin
      raw_height     = CMP_W'(csr_wdata[HEIGHT_FIELD_W-1:0]);
      height_in      = height_ff;
      back_top_in    = back_top_ff;
      back_bottom_in = back_bottom_ff;
      fore_top_in    = fore_top_ff;
      fore_bottom_in = fore_bottom_ff;
      recip_start    = 1'b0;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            REG_HEIGHT: begin
               recip_start = 1'b1;
               if (raw_height < CMP_W'(MIN_ROWS)) begin
                  height_in = H_W'(MIN_ROWS);
               end else if (raw_height > CMP_W'(MAX_ROWS)) begin
                  height_in = H_W'(MAX_ROWS);
               end else begin
                  height_in = H_W'(raw_height);
               end
            end
            REG_BACK_TOP:    back_top_in    = csr_wdata;
            REG_BACK_BOTTOM: back_bottom_in = csr_wdata;
            REG_FORE_TOP:    fore_top_in    = csr_wdata;
            REG_FORE_BOTTOM: fore_bottom_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff      <= H_W'(H_RESET);
         back_top_ff    <= '0;
         back_bottom_ff <= '0;
         fore_top_ff    <= '0;
         fore_bottom_ff <= '0;
      end else begin
         height_ff      <= height_in;
         back_top_ff    <= back_top_in;
         back_bottom_ff <= back_bottom_in;
         fore_top_ff    <= fore_top_in;
         fore_bottom_ff <= fore_bottom_in;
      end
   end

   stpr_recip u_recip (
      .clock  (clock),
      .reset  (reset),
      .start  (recip_start),
      .height (height_ff),
      .recip  (recip)
   );

   // Input stage.
   assign req_column = req_tdata[COL_FIELD_W-1:0];
   assign req_row    = req_tdata[COL_FIELD_W +: ROW_FIELD_W];
   assign req_level  = req_tdata[COL_FIELD_W+ROW_FIELD_W +: LEVEL_W];
   assign req_cmd    = command_type'(req_tuser);

   assign en1        = !v1_ff || take;
   assign req_tready = en1 && !recip.busy;
   assign accept     = req_tvalid && req_tready;

   assign col_addr  = COL_AW'(req_column);
   assign col_ok    = CMP_W'(req_column) < CMP_W'(COLUMNS);
   assign load_prod = (LEVEL_W+H_W)'(req_level) * (LEVEL_W+H_W)'(height_ff - H_W'(1));
   assign load_row  = load_prod[LEVEL_W +: ROW_W];
   assign wr_en     = accept && (req_cmd == CMD_LOAD) && col_ok;

   // A load writes at its own accept edge and a request reads at its own, so a request
   // that follows a load to the same column always sees the new row.
   stpr_ram #(.WIDTH(ROW_W), .DEPTH(COLUMNS)) u_ram_cur (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_addr),
      .wr_data (load_row),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (cur_row)
   );

   stpr_ram #(.WIDTH(ROW_W), .DEPTH(COLUMNS)) u_ram_prev (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_addr),
      .wr_data (load_row),
      .rd_en   (accept),
      .rd_addr (col_addr - COL_AW'(1)),
      .rd_data (prev_row)
   );

   assign v1_in              = en1 ? (accept && (req_cmd == CMD_PIXEL)) : v1_ff;
   assign meta1_in.y         = req_row;
   assign meta1_in.first_col = (req_column == '0);
   assign meta1_in.in_range  = col_ok && (CMP_W'(req_row) < CMP_W'(height_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         meta1_ff <= meta1_in;
      end
   end

   stpr_shade u_shade (
      .clock       (clock),
      .reset       (reset),
      .v1          (v1_ff),
      .meta1       (meta1_ff),
      .cur_row     (cur_row),
      .prev_row    (prev_row),
      .height      (height_ff),
      .recip       (recip.value),
      .back_top    (back_top_ff),
      .back_bottom (back_bottom_ff),
      .fore_top    (fore_top_ff),
      .fore_bottom (fore_bottom_ff),
      .take        (take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

`include "spectrum_trace_pixel_renderer_macros.svh"

   `STPR_ASSERT_SAME(a_no_accept_while_recip, req_tvalid && req_tready, !recip.busy)
   `STPR_ASSERT_NEXT(a_height_write_holds_req, csr_wen && (csr_addr == REG_HEIGHT), !req_tready)
   `STPR_ASSERT_NEXT(a_pixel_enters_pipe, req_tvalid && req_tready && (req_tuser == CMD_PIXEL), v1_ff)

endmodule

`default_nettype wire

// File: hdl/stpr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/stpr_recip.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring division of 2^N_W by the plot height, one quotient bit per cycle.
module stpr_recip import stpr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [H_W-1:0] height,
   output recip_type      recip
);

   logic                   busy_ff, busy_in;
   logic [RECIP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [H_W-1:0]         rem_ff, rem_in;
   logic [RECIP_W-1:0]     q_ff, q_in;
   logic [H_W:0]           rem_sh;
   logic [H_W:0]           rem_sub;
   logic                   ge;

   always_comb begin
      // The dividend is a single one followed by zeros.
      rem_sh  = {rem_ff, (cnt_ff == RECIP_CNT_W'(0))};
      ge      = rem_sh >= {1'b0, height};
      rem_sub = rem_sh - {1'b0, height};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[H_W-1:0] : rem_sh[H_W-1:0];
         q_in   = {q_ff[RECIP_W-2:0], ge};
         cnt_in = cnt_ff + RECIP_CNT_W'(1);
         if (cnt_ff == RECIP_CNT_W'(RECIP_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         q_ff    <= RECIP_W'(RECIP_RESET);
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         q_ff    <= q_in;
      end
   end

   assign recip.busy  = busy_ff;
   assign recip.value = q_ff;

endmodule

`default_nettype wire

// File: hdl/stpr_shade.sv
`timescale 1ns / 1ps
`default_nettype none

// Classifies a pixel against the stored rows, then forms the gradient in three stages:
// numerator, quotient estimate by reciprocal, remainder correction.
module stpr_shade import stpr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   v1,
   input  pix_meta_type           meta1,
   input  logic [ROW_W-1:0]       cur_row,
   input  logic [ROW_W-1:0]       prev_row,
   input  logic [H_W-1:0]         height,
   input  logic [RECIP_W-1:0]     recip,
   input  logic [COLOR_W-1:0]     back_top,
   input  logic [COLOR_W-1:0]     back_bottom,
   input  logic [COLOR_W-1:0]     fore_top,
   input  logic [COLOR_W-1:0]     fore_bottom,
   output logic                   take,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // red [7:0], green [15:8], blue [23:16]
);

   logic en2, en3, en4, en_out;
   logic v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in, vout_ff, vout_in;

   kind_type           kind2_ff, kind2_in, kind3_ff, kind4_ff;
   logic [H_W-1:0]     y2_ff;
   logic [COLOR_W-1:0] top2_ff, top2_in, bot2_ff, bot2_in;
   logic [N_W-1:0]     n3_ff [NUM_CHAN];
   logic [N_W-1:0]     n3_in [NUM_CHAN];
   logic [N_W-1:0]     n4_ff [NUM_CHAN];
   logic [CHAN_W-1:0]  q4_ff [NUM_CHAN];
   logic [CHAN_W-1:0]  q4_in [NUM_CHAN];
   logic [CHAN_W-1:0]  out_ff [NUM_CHAN];
   logic [CHAN_W-1:0]  out_in [NUM_CHAN];

   logic [CMP_W-1:0] y_c, r_c, p_c;
   logic             grey;

   // Bubbles collapse: a stage moves on whenever the one after it is empty or moving.
   assign en_out = !vout_ff || rsp_tready;
   assign en4    = !v4_ff || en_out;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign take   = en2;

   assign v2_in   = en2    ? v1      : v2_ff;
   assign v3_in   = en3    ? v2_ff   : v3_ff;
   assign v4_in   = en4    ? v3_ff   : v4_ff;
   assign vout_in = en_out ? v4_ff   : vout_ff;

   always_comb begin
      y_c  = CMP_W'(meta1.y);
      r_c  = CMP_W'(cur_row);
      p_c  = CMP_W'(prev_row);
      grey = 1'b0;
      if (!meta1.first_col) begin
         if (p_c > r_c) begin
            grey = (y_c > r_c) && (y_c <= p_c);
         end else if (p_c < r_c) begin
            grey = (y_c >= p_c) && (y_c < r_c);
         end
      end

      if (!meta1.in_range) begin
         kind2_in = KIND_ZERO;
      end else if (y_c == r_c) begin
         kind2_in = KIND_WHITE;
      end else if (grey) begin
         kind2_in = KIND_GREY;
      end else if (y_c < r_c) begin
         kind2_in = KIND_BACK;
      end else begin
         kind2_in = KIND_FORE;
      end

      if (y_c < r_c) begin
         top2_in = back_top;
         bot2_in = back_bottom;
      end else begin
         top2_in = fore_top;
         bot2_in = fore_bottom;
      end
   end

   // Numerator top * (height - y) + bottom * y per channel, red in the top byte.
   always_comb begin
      logic [CHAN_W+H_W-1:0] pt;
      logic [CHAN_W+H_W-1:0] pb;
      logic [CHAN_W+H_W:0]   sum;
      for (int c = 0; c < NUM_CHAN; c++) begin
         pt = (CHAN_W+H_W)'(top2_ff[CHAN_W*(NUM_CHAN-1-c) +: CHAN_W])
            * (CHAN_W+H_W)'(height - y2_ff);
         pb = (CHAN_W+H_W)'(bot2_ff[CHAN_W*(NUM_CHAN-1-c) +: CHAN_W])
            * (CHAN_W+H_W)'(y2_ff);
         sum = (CHAN_W+H_W+1)'(pt) + (CHAN_W+H_W+1)'(pb);
         n3_in[c] = sum[N_W-1:0];
      end
   end

   // The estimate from the floored reciprocal is the quotient or one below it.
   always_comb begin
      logic [2*N_W-1:0] prod;
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod = (2*N_W)'(n3_ff[c]) * (2*N_W)'(recip);
         q4_in[c] = prod[N_W +: CHAN_W];
      end
   end

   always_comb begin
      logic [CHAN_W+H_W-1:0] qh;
      logic [N_W-1:0]        rem;
      logic [CHAN_W-1:0]     blend;
      for (int c = 0; c < NUM_CHAN; c++) begin
         qh    = (CHAN_W+H_W)'(q4_ff[c]) * (CHAN_W+H_W)'(height);
         rem   = n4_ff[c] - qh[N_W-1:0];
         blend = q4_ff[c] + CHAN_W'(rem >= N_W'(height));
         case (kind4_ff)
            KIND_ZERO:  out_in[c] = '0;
            KIND_WHITE: out_in[c] = WHITE_LEVEL;
            KIND_GREY:  out_in[c] = GREY_LEVEL;
            default:    out_in[c] = blend;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         v4_ff   <= v4_in;
         vout_ff <= vout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         kind2_ff <= kind2_in;
         y2_ff    <= H_W'(meta1.y);
         top2_ff  <= top2_in;
         bot2_ff  <= bot2_in;
      end
      if (en3) begin
         kind3_ff <= kind2_ff;
         n3_ff    <= n3_in;
      end
      if (en4) begin
         kind4_ff <= kind3_ff;
         n4_ff    <= n3_ff;
         q4_ff    <= q4_in;
      end
      if (en_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vout_ff;
   assign rsp_tdata  = {out_ff[2], out_ff[1], out_ff[0]};

endmodule

`default_nettype wire
